FILE: hw/rtl/text_mode_character_generator_top_assert.svh
// Assertion macros for the text-mode character generator checker.
// Used by tmcg_checker.sv only; no other dependencies.
`ifndef TEXT_MODE_CHARACTER_GENERATOR_TOP_ASSERT_SVH
`define TEXT_MODE_CHARACTER_GENERATOR_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TMCG_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define TMCG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tmcg_pkg.sv
// Shared constants, codes and types for the text-mode character generator.
// No dependencies; used by all other files but the checker and its header.
package tmcg_pkg;

    // Screen geometry
    localparam int COLS          = 40;
    localparam int ROWS          = 25;
    localparam int GLYPH_HEIGHT  = 8;
    localparam int STATUS_ROWS   = 5;
    localparam int TOTAL_LINES   = 240;
    localparam int CODES         = 256;

    localparam int SCREEN_DEPTH  = COLS * ROWS;
    localparam int STATUS_DEPTH  = COLS * STATUS_ROWS;
    localparam int GLYPH_DEPTH   = CODES * GLYPH_HEIGHT;
    localparam int SCREEN_LINES  = ROWS * GLYPH_HEIGHT;
    // Screen area followed by the status area in one character memory
    localparam int CHAR_DEPTH    = SCREEN_DEPTH + STATUS_DEPTH;

    // Field and address widths
    localparam int OP_W          = 2;
    localparam int ADDR_W        = 11;
    localparam int DATA_W        = 8;
    localparam int LINE_W        = 8;
    localparam int COL_W         = 6;
    localparam int SCREEN_AW     = $clog2(SCREEN_DEPTH);
    localparam int STATUS_AW     = $clog2(STATUS_DEPTH);
    localparam int CHAR_AW       = $clog2(CHAR_DEPTH);
    localparam int GLYPH_AW      = $clog2(GLYPH_DEPTH);
    localparam int PIXROW_W      = $clog2(GLYPH_HEIGHT);
    // Width for the small address arithmetic
    localparam int CALC_W        = 16;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WR_SCREEN = 2'd0,
        OP_WR_STATUS = 2'd1,
        OP_WR_GLYPH  = 2'd2,
        OP_RENDER    = 2'd3
    } op_t;

    // One input item
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
    } in_item_t;

    // Pipeline handshake controls
    typedef struct packed {
        logic accept;   // input transfer this edge
        logic adv1;     // character stage may load
        logic adv2;     // glyph stage may load
    } pipe_ctl_t;

    // Memory write request
    typedef struct packed {
        logic                en;
        logic [GLYPH_AW-1:0] addr;
        logic [DATA_W-1:0]   data;
    } glyph_wr_t;

    // Character stage contents
    typedef struct packed {
        logic                valid;
        logic                zero;
        logic                vblank;
        logic [PIXROW_W-1:0] pixrow;
    } s1_t;

    // Result stage contents
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] pixels;
        logic              vblank;
    } s2_t;

endpackage

FILE: hw/rtl/tmcg_if.sv
// Stream interfaces for the input items and the result items.
// Depends on tmcg_pkg.
interface tmcg_in_if;
    logic                      valid;
    logic                      ready;
    tmcg_pkg::op_t             op;
    logic [tmcg_pkg::ADDR_W-1:0] addr;
    logic [tmcg_pkg::DATA_W-1:0] wdata;
    logic [tmcg_pkg::LINE_W-1:0] line;
    logic [tmcg_pkg::COL_W-1:0]  column;

    modport source (output valid, op, addr, wdata, line, column, input ready);
    modport sink   (input valid, op, addr, wdata, line, column, output ready);
endinterface

interface tmcg_out_if;
    logic                        valid;
    logic                        ready;
    logic [tmcg_pkg::DATA_W-1:0] pixels;
    logic                        vblank_flag;

    modport source (output valid, pixels, vblank_flag, input ready);
    modport sink   (input valid, pixels, vblank_flag, output ready);
endinterface

FILE: hw/rtl/tmcg_char_stage.sv
// Character stage: character store (screen and status areas), cell address decode,
// vblank flag. Depends on tmcg_pkg.
module tmcg_char_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  tmcg_pkg::pipe_ctl_t ctl,
    input  tmcg_pkg::in_item_t  item,
    output tmcg_pkg::s1_t       s1,
    output logic [tmcg_pkg::DATA_W-1:0] code
);
    import tmcg_pkg::*;

    // Screen area at 0, status area right after it
    logic [DATA_W-1:0] char_mem [CHAR_DEPTH];

    logic [DATA_W-1:0]   char_rd_reg;
    logic                s1_valid_reg;
    logic                s1_zero_reg;
    logic                s1_vblank_reg;
    logic [PIXROW_W-1:0] s1_pixrow_reg;
    logic                blank_reg;
    logic                blank_next;

    logic [CALC_W-1:0] line_w;
    logic [CALC_W-1:0] col_w;
    logic [CALC_W-1:0] off_w;
    logic [CALC_W-1:0] row_w;
    logic [CALC_W-1:0] pix_w;
    logic [CALC_W-1:0] cell_a;
    logic [CALC_W-1:0] rd_a;
    logic [CALC_W-1:0] wr_a;
    logic              is_screen;
    logic              zero;
    logic              render;
    logic              scr_wr;
    logic              sts_wr;
    logic              char_wr;

    // Cell address decode from line and column
    always_comb
    begin
        line_w    = CALC_W'(item.line);
        col_w     = CALC_W'(item.column);
        is_screen = (line_w < SCREEN_LINES);
        off_w     = is_screen ? line_w : line_w - CALC_W'(SCREEN_LINES);
        row_w     = CALC_W'(off_w / GLYPH_HEIGHT);
        pix_w     = CALC_W'(off_w % GLYPH_HEIGHT);
        cell_a    = CALC_W'(row_w * CALC_W'(COLS)) + col_w;
        rd_a      = is_screen ? cell_a : cell_a + CALC_W'(SCREEN_DEPTH);
        zero      = (col_w >= COLS) || (line_w >= TOTAL_LINES) ||
                    (is_screen ? (cell_a >= SCREEN_DEPTH)
                               : ((row_w >= STATUS_ROWS) || (cell_a >= STATUS_DEPTH)));
    end

    assign render  = ctl.accept && (item.op == OP_RENDER);
    assign scr_wr  = ctl.accept && (item.op == OP_WR_SCREEN) &&
                     (CALC_W'(item.addr) < SCREEN_DEPTH);
    assign sts_wr  = ctl.accept && (item.op == OP_WR_STATUS) &&
                     (CALC_W'(item.addr) < STATUS_DEPTH);
    assign char_wr = scr_wr || sts_wr;
    assign wr_a    = sts_wr ? CALC_W'(item.addr) + CALC_W'(SCREEN_DEPTH)
                            : CALC_W'(item.addr);

    // Flag: line 0 clears, last line sets
    always_comb
    begin
        blank_next = blank_reg;
        if (line_w == 0)
        begin
            blank_next = 1'b0;
        end
        if (line_w == CALC_W'(TOTAL_LINES - 1))
        begin
            blank_next = 1'b1;
        end
    end

    // Character store: write on transfer, read when the stage loads a render
    always_ff @(posedge clk)
    begin
        if (render && !zero)
        begin
            char_rd_reg <= char_mem[rd_a[CHAR_AW-1:0]];
        end
        if (char_wr)
        begin
            char_mem[wr_a[CHAR_AW-1:0]] <= item.wdata;
        end
    end

    // Stage control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            blank_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.adv1)
            begin
                s1_valid_reg <= render;
            end
            if (render)
            begin
                blank_reg <= blank_next;
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (render)
        begin
            s1_zero_reg   <= zero;
            s1_vblank_reg <= blank_next;
            s1_pixrow_reg <= pix_w[PIXROW_W-1:0];
        end
    end

    assign s1.valid  = s1_valid_reg;
    assign s1.zero   = s1_zero_reg;
    assign s1.vblank = s1_vblank_reg;
    assign s1.pixrow = s1_pixrow_reg;
    assign code      = char_rd_reg;

endmodule

FILE: hw/rtl/tmcg_glyph_stage.sv
// Glyph stage: glyph store and the result register.
// Depends on tmcg_pkg.
module tmcg_glyph_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  tmcg_pkg::glyph_wr_t  wr,
    input  tmcg_pkg::s1_t        s1,
    input  logic [tmcg_pkg::DATA_W-1:0] code,
    output tmcg_pkg::s2_t        res
);
    import tmcg_pkg::*;

    logic [DATA_W-1:0] glyph_mem [GLYPH_DEPTH];

    logic [DATA_W-1:0]   glyph_rd_reg;
    logic                s2_valid_reg;
    logic                s2_zero_reg;
    logic                s2_vblank_reg;
    logic [GLYPH_AW-1:0] glyph_a;
    logic [CALC_W-1:0]   glyph_sum;
    logic                load;

    // Glyph byte address: code times height plus pixel row
    assign glyph_sum = CALC_W'(CALC_W'(code) * CALC_W'(GLYPH_HEIGHT)) + CALC_W'(s1.pixrow);
    assign glyph_a   = glyph_sum[GLYPH_AW-1:0];
    assign load      = advance && s1.valid;

    // Read sees the old byte when a later write lands on the same edge
    always_ff @(posedge clk)
    begin
        if (load && !s1.zero)
        begin
            glyph_rd_reg <= glyph_mem[glyph_a];
        end
        if (wr.en)
        begin
            glyph_mem[wr.addr] <= wr.data;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1.valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_zero_reg   <= s1.zero;
            s2_vblank_reg <= s1.vblank;
        end
    end

    assign res.valid  = s2_valid_reg;
    assign res.pixels = s2_zero_reg ? '0 : glyph_rd_reg;
    assign res.vblank = s2_vblank_reg;

endmodule

FILE: hw/rtl/text_mode_character_generator_top.sv
// Text-mode character generator, top level: handshake control and stage wiring.
// Depends on tmcg_pkg, tmcg_if, tmcg_char_stage and tmcg_glyph_stage.
//
// Takes one item per clock while the input is ready: writes to the screen,
// status or glyph store, and render items that each return one cell of eight
// pixels (bit 7 leftmost, 1 white) with the vblank flag. A render reads the
// character code from the character memory, which holds the screen area
// followed by the status area, into the character stage, then the glyph byte
// from the glyph memory into the result stage; each memory has one synchronous
// read port. Writes take effect at their own transfer and are seen by every
// later render. Stores come up undefined after reset and need no clearing
// pass; only the vblank flag (to 0) and the stage valid bits reset. The input
// stays ready while a result waits, as long as the character stage is free.
module text_mode_character_generator_top (
    input logic        clk,
    input logic        rst_n,
    tmcg_in_if.sink    in_ch,
    tmcg_out_if.source out_ch
);
    import tmcg_pkg::*;

    pipe_ctl_t         ctl;
    in_item_t          item;
    s1_t               s1;
    s2_t               res;
    glyph_wr_t         glyph_wr;
    logic [DATA_W-1:0] code;

    assign item.op     = in_ch.op;
    assign item.addr   = in_ch.addr;
    assign item.wdata  = in_ch.wdata;
    assign item.line   = in_ch.line;
    assign item.column = in_ch.column;

    // Each stage loads when the one after it moves or is empty
    assign ctl.adv2   = !res.valid || out_ch.ready;
    assign ctl.adv1   = !s1.valid || ctl.adv2;
    assign ctl.accept = in_ch.valid && ctl.adv1;

    // Glyph store write request
    assign glyph_wr.en   = ctl.accept && (item.op == OP_WR_GLYPH) &&
                           (CALC_W'(item.addr) < GLYPH_DEPTH);
    assign glyph_wr.addr = item.addr[GLYPH_AW-1:0];
    assign glyph_wr.data = item.wdata;

    tmcg_char_stage u_char_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .item  (item),
        .s1    (s1),
        .code  (code)
    );

    tmcg_glyph_stage u_glyph_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (ctl.adv2),
        .wr      (glyph_wr),
        .s1      (s1),
        .code    (code),
        .res     (res)
    );

    assign in_ch.ready        = ctl.adv1;
    assign out_ch.valid       = res.valid;
    assign out_ch.pixels      = res.pixels;
    assign out_ch.vblank_flag = res.vblank;

endmodule

FILE: hw/rtl/tmcg_checker.sv
// Port-level checker for the text-mode character generator, with its bind.
// Depends on text_mode_character_generator_top_assert.svh.
`include "text_mode_character_generator_top_assert.svh"

module tmcg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_pixels,
    input logic       out_vblank
);

    // A stalled result holds
    `TMCG_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_pixels) && $stable(out_vblank), "stalled result changed")

    // No result during reset
    `TMCG_ASSERT_ALWAYS(a_out_reset, clk, !rst_n |-> !out_valid, "result valid in reset")

    // With the result stage empty the input side must be open
    `TMCG_ASSERT_RST(a_in_open, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind text_mode_character_generator_top tmcg_checker u_tmcg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_pixels (out_ch.pixels),
    .out_vblank (out_ch.vblank_flag)
);

FILE: tb/tb_text_mode_character_generator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_mode_character_generator_top: a directed table, then
// random store writes and render cells, with random idling on both streams.
// Depends on tmcg_pkg, tmcg_if and the block's RTL.
module tb_text_mode_character_generator_top;
    import tmcg_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DIRECTED_COUNT = 24;

    // One rendered cell as it leaves the block
    typedef struct packed {
        logic [DATA_W-1:0] pixels;
        logic              vblank;
    } cell_result_t;

    // One input transfer; typed rows carry their own expected cell
    typedef struct {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        bit                typed;
        cell_result_t      want;
    } step_t;

    logic clk;
    logic rst_n;

    tmcg_in_if  in_ch ();
    tmcg_out_if out_ch ();

    text_mode_character_generator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the stores, which entries hold data, and the vblank flag
    logic [DATA_W-1:0] screen_chars [SCREEN_DEPTH];
    logic [DATA_W-1:0] status_chars [STATUS_DEPTH];
    logic [DATA_W-1:0] glyph_rows   [GLYPH_DEPTH];
    bit                screen_known [SCREEN_DEPTH];
    bit                status_known [STATUS_DEPTH];
    bit                glyph_known  [GLYPH_DEPTH];
    logic              vblank_now = 1'b0;

    cell_result_t pending_cells [$];
    int           fail_count   = 0;
    int           useful_items = 0;
    int           in_idle_pct  = 0;
    int           out_idle_pct = 0;
    int           cycle_count  = 0;
    bit           quiet        = 1'b0;

    // Directed table: op, addr, wdata, line, column, typed, expected {pixels, vblank}
    step_t directed_steps [DIRECTED_COUNT] = '{
        // all-ones line and column straight after reset: off screen, flag still clear
        '{OP_RENDER,    11'd2047, 8'hff, 8'd255, 6'd63, 1'b1, '{8'h00, 1'b0}},
        '{OP_WR_SCREEN, 11'd0,    8'hff, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_WR_GLYPH,  11'd2040, 8'h80, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_RENDER,    11'd0,    8'h00, 8'd0,   6'd0,  1'b1, '{8'h80, 1'b0}},
        // last screen cell, code 0, bottom glyph row
        '{OP_WR_SCREEN, 11'd999,  8'h00, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_WR_GLYPH,  11'd7,    8'h01, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_RENDER,    11'd0,    8'h00, 8'd199, 6'd39, 1'b1, '{8'h01, 1'b0}},
        // last status cell on the last line sets vblank
        '{OP_WR_STATUS, 11'd199,  8'h80, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_WR_GLYPH,  11'd1031, 8'ha5, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_RENDER,    11'd0,    8'h00, 8'd239, 6'd39, 1'b1, '{8'ha5, 1'b1}},
        // line and column just past their ends give black, flag unchanged
        '{OP_RENDER,    11'd0,    8'h00, 8'd240, 6'd39, 1'b1, '{8'h00, 1'b1}},
        '{OP_RENDER,    11'd0,    8'h00, 8'd100, 6'd40, 1'b1, '{8'h00, 1'b1}},
        // writes past the end of the character stores are dropped; then status cell 0 is drawn
        '{OP_WR_SCREEN, 11'd1000, 8'h55, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_WR_STATUS, 11'd200,  8'haa, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_WR_STATUS, 11'd0,    8'h7f, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_WR_GLYPH,  11'd2047, 8'hff, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_WR_GLYPH,  11'd1016, 8'h3c, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_RENDER,    11'd0,    8'h00, 8'd200, 6'd0,  1'b1, '{8'h3c, 1'b1}},
        // line 0 clears vblank
        '{OP_RENDER,    11'd0,    8'h00, 8'd0,   6'd0,  1'b1, '{8'h80, 1'b0}},
        '{OP_RENDER,    11'd0,    8'h00, 8'd7,   6'd0,  1'b1, '{8'hff, 1'b0}},
        // rewrite a character already shown
        '{OP_WR_SCREEN, 11'd0,    8'h00, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_WR_GLYPH,  11'd0,    8'h00, 8'd0,   6'd0,  1'b0, '{8'h00, 1'b0}},
        '{OP_RENDER,    11'd0,    8'h00, 8'd0,   6'd0,  1'b1, '{8'h00, 1'b0}},
        '{OP_RENDER,    11'd0,    8'h00, 8'd7,   6'd0,  1'b1, '{8'h01, 1'b0}}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Map a render position to its character slot and glyph row; 0 when off screen
    function automatic bit cell_slot(input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] col,
                                     output bit from_status, output int unsigned idx,
                                     output int unsigned prow);
        int unsigned l;
        int unsigned r;
        l           = 32'(ln);
        from_status = 1'b0;
        idx         = 0;
        prow        = 0;
        if (col >= COLS || l >= TOTAL_LINES)
            return 1'b0;
        from_status = (l >= SCREEN_LINES);
        if (from_status)
            l = l - SCREEN_LINES;
        r    = l / GLYPH_HEIGHT;
        prow = l % GLYPH_HEIGHT;
        if (from_status && r >= STATUS_ROWS)
            return 1'b0;
        idx = r * COLS + col;
        return 1'b1;
    endfunction

    function automatic int unsigned char_at(input bit from_status, input int unsigned idx);
        return from_status ? 32'(status_chars[idx[STATUS_AW-1:0]])
                           : 32'(screen_chars[idx[SCREEN_AW-1:0]]);
    endfunction

    function automatic bit char_known(input bit from_status, input int unsigned idx);
        return from_status ? status_known[idx[STATUS_AW-1:0]]
                           : screen_known[idx[SCREEN_AW-1:0]];
    endfunction

    // True when rendering here reads only store entries that hold data
    function automatic bit cell_defined(input logic [LINE_W-1:0] ln,
                                        input logic [COL_W-1:0] col);
        bit          st;
        int unsigned idx;
        int unsigned prow;
        int unsigned ga;
        if (!cell_slot(ln, col, st, idx, prow))
            return 1'b1;
        if (!char_known(st, idx))
            return 1'b0;
        ga = char_at(st, idx) * GLYPH_HEIGHT + prow;
        return glyph_known[ga[GLYPH_AW-1:0]];
    endfunction

    // Apply one accepted transfer to the shadow state; 1 with the cell for a render
    function automatic bit predict_cell(input step_t s, output cell_result_t res);
        bit          st;
        int unsigned idx;
        int unsigned prow;
        int unsigned ga;
        res = '0;
        case (s.op)
            OP_WR_SCREEN:
                if (s.addr < SCREEN_DEPTH)
                begin
                    screen_chars[s.addr[SCREEN_AW-1:0]] = s.wdata;
                    screen_known[s.addr[SCREEN_AW-1:0]] = 1'b1;
                end
            OP_WR_STATUS:
                if (s.addr < STATUS_DEPTH)
                begin
                    status_chars[s.addr[STATUS_AW-1:0]] = s.wdata;
                    status_known[s.addr[STATUS_AW-1:0]] = 1'b1;
                end
            OP_WR_GLYPH:
                if (s.addr < GLYPH_DEPTH)
                begin
                    glyph_rows[s.addr]  = s.wdata;
                    glyph_known[s.addr] = 1'b1;
                end
            default: ;
        endcase
        if (s.op != OP_RENDER)
            return 1'b0;
        // flag follows lines 0 and TOTAL_LINES-1 whatever the column
        if (s.line == 0)
            vblank_now = 1'b0;
        if (s.line == TOTAL_LINES - 1)
            vblank_now = 1'b1;
        if (cell_slot(s.line, s.column, st, idx, prow))
        begin
            ga         = char_at(st, idx) * GLYPH_HEIGHT + prow;
            res.pixels = glyph_rows[ga[GLYPH_AW-1:0]];
        end
        res.vblank = vblank_now;
        return 1'b1;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    function automatic step_t random_step(input op_t op);
        step_t s;
        s.op     = op;
        s.addr   = ADDR_W'($urandom_range(0, 2**ADDR_W - 1));
        s.wdata  = DATA_W'($urandom_range(0, 2**DATA_W - 1));
        s.line   = LINE_W'($urandom_range(0, 2**LINE_W - 1));
        s.column = COL_W'($urandom_range(0, 2**COL_W - 1));
        s.typed  = 1'b0;
        s.want   = '0;
        return s;
    endfunction

    // Drive one item until its transfer, then record what it should produce
    task automatic send_item(input step_t s);
        cell_result_t res;
        if (!quiet && $urandom_range(1, 100) <= in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.op     <= s.op;
        in_ch.addr   <= s.addr;
        in_ch.wdata  <= s.wdata;
        in_ch.line   <= s.line;
        in_ch.column <= s.column;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (predict_cell(s, res))
            pending_cells.push_back(s.typed ? s.want : res);
        // dropped writes do not count toward the random budget
        if (!((s.op == OP_WR_SCREEN && s.addr >= SCREEN_DEPTH) ||
              (s.op == OP_WR_STATUS && s.addr >= STATUS_DEPTH)))
            useful_items++;
        if (useful_items % 50 == 0)
            in_idle_pct = pick_idle_pct();
    endtask

    // Write whatever a visible cell still lacks (sometimes rewrite it), then render it
    task automatic render_sequence();
        step_t       s;
        step_t       w;
        bit          st;
        int unsigned idx;
        int unsigned prow;
        int unsigned gaddr;
        s = random_step(OP_RENDER);
        case ($urandom_range(0, 9))
            0:       s.line = '0;
            1:       s.line = LINE_W'(TOTAL_LINES - 1);
            default: s.line = LINE_W'($urandom_range(0, TOTAL_LINES - 1));
        endcase
        s.column = COL_W'($urandom_range(0, COLS - 1));
        void'(cell_slot(s.line, s.column, st, idx, prow));
        if (!char_known(st, idx) || $urandom_range(0, 3) == 0)
        begin
            w      = random_step(st ? OP_WR_STATUS : OP_WR_SCREEN);
            w.addr = ADDR_W'(idx);
            // a narrow code range makes cells share glyphs
            if ($urandom_range(0, 1))
                w.wdata = DATA_W'($urandom_range(0, 15));
            send_item(w);
        end
        gaddr = char_at(st, idx) * GLYPH_HEIGHT + prow;
        if (!glyph_known[gaddr[GLYPH_AW-1:0]] || $urandom_range(0, 3) == 0)
        begin
            w      = random_step(OP_WR_GLYPH);
            w.addr = ADDR_W'(gaddr);
            send_item(w);
        end
        send_item(s);
    endtask

    // Loose writes anywhere, off-screen renders and renders of cells already filled
    task automatic send_noise();
        step_t s;
        case ($urandom_range(0, 4))
            0: s = random_step(OP_WR_SCREEN);
            1: s = random_step(OP_WR_STATUS);
            2: s = random_step(OP_WR_GLYPH);
            3:
            begin
                s = random_step(OP_RENDER);
                if ($urandom_range(0, 1))
                    s.line = LINE_W'($urandom_range(TOTAL_LINES, 2**LINE_W - 1));
                else
                    s.column = COL_W'($urandom_range(COLS, 2**COL_W - 1));
            end
            default:
            begin
                s = random_step(OP_RENDER);
                if (!cell_defined(s.line, s.column))
                    s.column = COL_W'($urandom_range(COLS, 2**COL_W - 1));
            end
        endcase
        send_item(s);
    endtask

    // Stimulus
    initial
    begin
        int random_start;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.op     <= OP_WR_SCREEN;
        in_ch.addr   <= '0;
        in_ch.wdata  <= '0;
        in_ch.line   <= '0;
        in_ch.column <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            send_item(directed_steps[i]);

        // random traffic; the final stretch runs with no idling
        random_start = useful_items;
        while (useful_items - random_start < RANDOM_ITEMS)
        begin
            if (useful_items - random_start >= RANDOM_ITEMS * 85 / 100)
                quiet = 1'b1;
            if ($urandom_range(0, 9) < 7)
                render_sequence();
            else
                send_noise();
        end
        in_ch.valid <= 1'b0;

        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side: check each transfer against the oldest expected cell, stall in bursts
    initial
    begin
        int           stall_left;
        cell_result_t want;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_cells.size() == 0)
                begin
                    fail_count++;
                    $error("unexpected result: pixels 0x%02h vblank_flag %0b",
                           out_ch.pixels, out_ch.vblank_flag);
                end
                else
                begin
                    want = pending_cells.pop_front();
                    if (out_ch.pixels !== want.pixels)
                    begin
                        fail_count++;
                        $error("pixels: expected 0x%02h, got 0x%02h", want.pixels, out_ch.pixels);
                    end
                    if (out_ch.vblank_flag !== want.vblank)
                    begin
                        fail_count++;
                        $error("vblank_flag: expected %0b, got %0b",
                               want.vblank, out_ch.vblank_flag);
                    end
                end
            end
            if (cycle_count % 64 == 0)
                out_idle_pct = pick_idle_pct();
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && rst_n && $urandom_range(1, 100) <= out_idle_pct)
            begin
                stall_left   = $urandom_range(1, 10) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
